>>> design/spo_pkg.sv
// spo_pkg: shared types, constants and the micro-op schedule of the sine phase oscillator.
// Used by spo_ctrl, spo_datapath and sine_phase_oscillator_core; depends on nothing.

package spo_pkg;

    // Phase width default and register reset
    localparam int          PHASE_BITS_DEFAULT = 32;
    localparam logic [31:0] RATE_FACTOR_RESET  = 32'd24932236;

    // Fixed-point constants (Q29 two pi, full-scale sample, one in Q30)
    localparam logic [32:0] TWO_PI_Q29 = 33'd3373259426;
    localparam logic [30:0] FULL_SCALE = 31'h7FFF_FFFF;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

    // Odd divisors after peeling the power-of-two factor off each constant divisor:
    // 6, 42, 110, 210 are twice 3, 21, 55, 105; 120, 3024, 17160 are 8*15, 16*189, 8*2145.
    localparam int D_Q1  = 3;
    localparam int D_Q5  = 21;
    localparam int D_Q9  = 55;
    localparam int D_Q13 = 105;
    localparam int D_G5  = 15;
    localparam int D_G9  = 189;
    localparam int D_G13 = 2145;

    // Exact reciprocals for 32-bit dividends: q = (n * M) >> K
    localparam int K_Q1  = 32 + $clog2(D_Q1);
    localparam int K_Q5  = 32 + $clog2(D_Q5);
    localparam int K_Q9  = 32 + $clog2(D_Q9);
    localparam int K_Q13 = 32 + $clog2(D_Q13);
    localparam int K_G5  = 32 + $clog2(D_G5);
    localparam int K_G9  = 32 + $clog2(D_G9);
    localparam int K_G13 = 32 + $clog2(D_G13);

    localparam logic [32:0] M_Q1  =
        33'(((64'd1 << K_Q1) + 64'(D_Q1) - 64'd1) / 64'(D_Q1));
    localparam logic [32:0] M_Q5  =
        33'(((64'd1 << K_Q5) + 64'(D_Q5) - 64'd1) / 64'(D_Q5));
    localparam logic [32:0] M_Q9  =
        33'(((64'd1 << K_Q9) + 64'(D_Q9) - 64'd1) / 64'(D_Q9));
    localparam logic [32:0] M_Q13 =
        33'(((64'd1 << K_Q13) + 64'(D_Q13) - 64'd1) / 64'(D_Q13));
    localparam logic [32:0] M_G5  =
        33'(((64'd1 << K_G5) + 64'(D_G5) - 64'd1) / 64'(D_G5));
    localparam logic [32:0] M_G9  =
        33'(((64'd1 << K_G9) + 64'(D_G9) - 64'd1) / 64'(D_G9));
    localparam logic [32:0] M_G13 =
        33'(((64'd1 << K_G13) + 64'(D_G13) - 64'd1) / 64'(D_G13));

    // Sequencer length
    localparam int STEP_COUNT = 22;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_LAST = t_step'(STEP_COUNT - 1);

    // Multiplier operations; the same code, registered, steers the write-back in the following cycle
    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_X,
        MOP_STEP,
        MOP_X2,
        MOP_X4,
        MOP_Q13,
        MOP_Q9,
        MOP_Q5,
        MOP_Q1,
        MOP_N5,
        MOP_G5,
        MOP_N9,
        MOP_G9,
        MOP_N13,
        MOP_G13,
        MOP_T1,
        MOP_T5,
        MOP_T9,
        MOP_T13,
        MOP_MAG
    } t_mop;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic load_out;
        t_mop op;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_hold;
    } t_dp_status;

    // Issue schedule: a result passes the product register and its write-back before it is
    // usable, so independent divisions fill the gaps of the dependent chain
    function automatic t_mop mop_at(input t_step step);
        t_mop op;
        case (step)
            t_step'(0):  op = MOP_X;
            t_step'(1):  op = MOP_STEP;
            t_step'(2):  op = MOP_X2;
            t_step'(4):  op = MOP_X4;
            t_step'(5):  op = MOP_Q13;
            t_step'(6):  op = MOP_N5;
            t_step'(7):  op = MOP_Q9;
            t_step'(8):  op = MOP_G5;
            t_step'(9):  op = MOP_Q5;
            t_step'(10): op = MOP_N9;
            t_step'(11): op = MOP_Q1;
            t_step'(12): op = MOP_G9;
            t_step'(13): op = MOP_T1;
            t_step'(14): op = MOP_N13;
            t_step'(15): op = MOP_T5;
            t_step'(16): op = MOP_G13;
            t_step'(17): op = MOP_T9;
            t_step'(18): op = MOP_T13;
            t_step'(20): op = MOP_MAG;
            default:     op = MOP_NONE;
        endcase
        return op;
    endfunction

endpackage

>>> design/sine_phase_oscillator_core.sv
// sine_phase_oscillator_core: top level of the sine phase oscillator.
// Depends on spo_pkg, spo_ctrl and spo_datapath.

// Each input beat carries a frequency (Hz, 8 fractional bits) and yields one output beat:
// the sine of the current phase times 2147483647, truncated toward zero, after which
// the phase advances by (frequency * rate_factor) >> (48 - PHASE_BITS), wrapping.
// An item is accepted, runs through 22 sequencer steps on a single shared 33x33
// multiplier that evaluates the folded odd polynomial (divisions by constants done
// as reciprocal multiplies), and is then moved into the output register.
// The output register lets the next beat be accepted while a sample waits; a new item
// finishes only once that sample is taken. rate_factor is written through
// i_cfg_wr_en/i_cfg_wr_data and should only change while the block is idle.

module sine_phase_oscillator_core #(
    parameter int PHASE_BITS = spo_pkg::PHASE_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_frequency,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    spo_pkg::t_dp_cmd    w_cmd;
    spo_pkg::t_dp_status w_status;

    // Sequencer
    spo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Arithmetic and storage
    spo_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_frequency   (i_frequency),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample)
    );

endmodule

>>> design/spo_ctrl.sv
// spo_ctrl: controller of the sine phase oscillator; runs the micro-op sequence per beat.
// Depends on spo_pkg.

module spo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  spo_pkg::t_dp_status i_status,
    output spo_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state         r_state, n_state;
    spo_pkg::t_step r_step, n_step;

    // Input beat taken only when idle
    assign o_stall = (r_state != ST_IDLE);

    // Commands
    always_comb begin
        o_cmd.start    = (r_state == ST_IDLE) && i_valid;
        o_cmd.load_out = (r_state == ST_DONE) && !i_status.out_hold;
        o_cmd.op       = (r_state == ST_RUN) ? spo_pkg::mop_at(r_step) : spo_pkg::MOP_NONE;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == spo_pkg::STEP_LAST) begin
                    n_state = ST_DONE;
                    n_step  = '0;
                end else begin
                    n_step = r_step + spo_pkg::t_step'(1);
                end
            end
            ST_DONE: begin
                if (!i_status.out_hold) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Sequencer walks the steps one per cycle
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != spo_pkg::STEP_LAST) |=>
        (r_state == ST_RUN && r_step == $past(r_step) + spo_pkg::t_step'(1)))
        else $error("sequencer step did not advance");

    // Last step always hands over to the output stage
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == spo_pkg::STEP_LAST) |=> (r_state == ST_DONE))
        else $error("sequence did not finish after last step");

endmodule

>>> design/spo_datapath.sv
// spo_datapath: phase accumulator, shared 33x33 multiplier, write-back registers,
// rate register and output register of the sine phase oscillator. Depends on spo_pkg.

module spo_datapath #(
    parameter int PHASE_BITS = spo_pkg::PHASE_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spo_pkg::t_dp_cmd    i_cmd,
    output spo_pkg::t_dp_status o_status,
    input  logic [23:0]         i_frequency,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_sample
);

    localparam int STEP_SHIFT = 48 - PHASE_BITS;

    // Quadrant codes from the top two phase bits
    localparam logic [1:0] QUAD_RISE    = 2'd0;
    localparam logic [1:0] QUAD_FALL    = 2'd1;
    localparam logic [1:0] QUAD_NEG_GO  = 2'd2;
    localparam logic [1:0] QUAD_NEG_RET = 2'd3;

    // State and control
    logic [PHASE_BITS-1:0] r_phase;
    logic [31:0]           r_rate;
    logic                  r_out_valid;
    spo_pkg::t_mop         r_wb_op;

    // Payload
    logic [23:0] r_freq;
    logic        r_neg;
    logic [65:0] r_prod;
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [32:0] r_x4;
    logic [31:0] r_n;
    logic [30:0] r_g5, r_g9, r_g13;
    logic [30:0] r_u1, r_u5, r_u9, r_u13;
    logic [31:0] r_s;
    logic [30:0] r_mag;
    logic [31:0] r_sample;

    logic [31:0]           w_p32;
    logic [32:0]           w_a_full;
    logic [30:0]           w_a;
    logic [32:0]           w_mul_a, w_mul_b;
    logic [65:0]           w_prod;
    logic [PHASE_BITS-1:0] w_step_inc;
    logic [35:0]           w_mag_full;

    // Top 32 phase bits
    if (PHASE_BITS >= 32) begin : g_wide
        assign w_p32 = r_phase[PHASE_BITS-1 -: 32];
    end else begin : g_narrow
        assign w_p32 = {r_phase, {(32 - PHASE_BITS){1'b0}}};
    end

    // Fold to distance from the nearest zero crossing
    always_comb begin
        case (w_p32[31:30])
            QUAD_RISE:    w_a_full = {1'b0, w_p32};
            QUAD_FALL:    w_a_full = 33'h0_8000_0000 - {1'b0, w_p32};
            QUAD_NEG_GO:  w_a_full = {1'b0, w_p32} - 33'h0_8000_0000;
            QUAD_NEG_RET: w_a_full = 33'h1_0000_0000 - {1'b0, w_p32};
            default:      w_a_full = '0;
        endcase
    end
    assign w_a = w_a_full[30:0];

    // Multiplier operand select
    always_comb begin
        case (i_cmd.op)
            spo_pkg::MOP_X: begin
                w_mul_a = {2'b0, w_a};
                w_mul_b = spo_pkg::TWO_PI_Q29;
            end
            spo_pkg::MOP_STEP: begin
                w_mul_a = {9'b0, r_freq};
                w_mul_b = {1'b0, r_rate};
            end
            spo_pkg::MOP_X2: begin
                w_mul_a = {2'b0, r_x};
                w_mul_b = {2'b0, r_x};
            end
            spo_pkg::MOP_X4: begin
                w_mul_a = {1'b0, r_x2};
                w_mul_b = {1'b0, r_x2};
            end
            spo_pkg::MOP_Q13: begin
                w_mul_a = {2'b0, r_x2[31:1]};
                w_mul_b = spo_pkg::M_Q13;
            end
            spo_pkg::MOP_Q9: begin
                w_mul_a = {2'b0, r_x2[31:1]};
                w_mul_b = spo_pkg::M_Q9;
            end
            spo_pkg::MOP_Q5: begin
                w_mul_a = {2'b0, r_x2[31:1]};
                w_mul_b = spo_pkg::M_Q5;
            end
            spo_pkg::MOP_Q1: begin
                w_mul_a = {2'b0, r_x2[31:1]};
                w_mul_b = spo_pkg::M_Q1;
            end
            spo_pkg::MOP_N5: begin
                w_mul_a = {2'b0, r_x};
                w_mul_b = r_x4;
            end
            spo_pkg::MOP_G5: begin
                w_mul_a = {1'b0, r_n};
                w_mul_b = spo_pkg::M_G5;
            end
            spo_pkg::MOP_N9: begin
                w_mul_a = {2'b0, r_g5};
                w_mul_b = r_x4;
            end
            spo_pkg::MOP_G9: begin
                w_mul_a = {1'b0, r_n};
                w_mul_b = spo_pkg::M_G9;
            end
            spo_pkg::MOP_N13: begin
                w_mul_a = {2'b0, r_g9};
                w_mul_b = r_x4;
            end
            spo_pkg::MOP_G13: begin
                w_mul_a = {1'b0, r_n};
                w_mul_b = spo_pkg::M_G13;
            end
            spo_pkg::MOP_T1: begin
                w_mul_a = {2'b0, r_x};
                w_mul_b = {2'b0, r_u1};
            end
            spo_pkg::MOP_T5: begin
                w_mul_a = {2'b0, r_g5};
                w_mul_b = {2'b0, r_u5};
            end
            spo_pkg::MOP_T9: begin
                w_mul_a = {2'b0, r_g9};
                w_mul_b = {2'b0, r_u9};
            end
            spo_pkg::MOP_T13: begin
                w_mul_a = {2'b0, r_g13};
                w_mul_b = {2'b0, r_u13};
            end
            spo_pkg::MOP_MAG: begin
                w_mul_a = {1'b0, r_s};
                w_mul_b = {2'b0, spo_pkg::FULL_SCALE};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_step_inc = r_prod[STEP_SHIFT +: PHASE_BITS];
    assign w_mag_full = r_prod[65:30];

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_rate      <= spo_pkg::RATE_FACTOR_RESET;
            r_out_valid <= 1'b0;
            r_wb_op     <= spo_pkg::MOP_NONE;
        end else begin
            r_wb_op <= i_cmd.op;
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            if (r_wb_op == spo_pkg::MOP_STEP) begin
                r_phase <= r_phase + w_step_inc;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Product register and write-back of the previous operation
    // (a reciprocal quotient is everything in the product above bit K)
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.start) begin
            r_freq <= i_frequency;
            r_neg  <= w_p32[31];
            r_s    <= '0;
        end
        case (r_wb_op)
            spo_pkg::MOP_X:   r_x   <= r_prod[31 +: 31];
            spo_pkg::MOP_X2:  r_x2  <= r_prod[30 +: 32];
            spo_pkg::MOP_X4:  r_x4  <= r_prod[30 +: 33];
            spo_pkg::MOP_Q13: r_u13 <= spo_pkg::Q30_ONE - 31'(r_prod[65:spo_pkg::K_Q13]);
            spo_pkg::MOP_Q9:  r_u9  <= spo_pkg::Q30_ONE - 31'(r_prod[65:spo_pkg::K_Q9]);
            spo_pkg::MOP_Q5:  r_u5  <= spo_pkg::Q30_ONE - 31'(r_prod[65:spo_pkg::K_Q5]);
            spo_pkg::MOP_Q1:  r_u1  <= spo_pkg::Q30_ONE - 31'(r_prod[65:spo_pkg::K_Q1]);
            // >>30 then >>3, >>4, >>3 strip the power-of-two part of each divisor
            spo_pkg::MOP_N5:  r_n   <= r_prod[33 +: 32];
            spo_pkg::MOP_N9:  r_n   <= r_prod[34 +: 32];
            spo_pkg::MOP_N13: r_n   <= r_prod[33 +: 32];
            spo_pkg::MOP_G5:  r_g5  <= 31'(r_prod[65:spo_pkg::K_G5]);
            spo_pkg::MOP_G9:  r_g9  <= 31'(r_prod[65:spo_pkg::K_G9]);
            spo_pkg::MOP_G13: r_g13 <= 31'(r_prod[65:spo_pkg::K_G13]);
            spo_pkg::MOP_T1,
            spo_pkg::MOP_T5,
            spo_pkg::MOP_T9,
            spo_pkg::MOP_T13: r_s   <= r_s + r_prod[30 +: 32];
            spo_pkg::MOP_MAG: begin
                if (w_mag_full > {5'b0, spo_pkg::FULL_SCALE}) begin
                    r_mag <= spo_pkg::FULL_SCALE;
                end else begin
                    r_mag <= w_mag_full[30:0];
                end
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_sample <= r_neg ? (32'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
        end
    end

    assign o_status.out_hold = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_sample          = r_sample;

    // Phase moves only on the step write-back
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wb_op != spo_pkg::MOP_STEP) |=> $stable(r_phase))
        else $error("phase changed outside step write-back");

    // Never overwrite a result still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_stall))
        else $error("output register loaded while held");

    // Saturation keeps the sample symmetric
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sample != 32'h8000_0000))
        else $error("sample outside full-scale range");

endmodule

>>> bench/tb_sine_phase_oscillator_core.sv
// tb_sine_phase_oscillator_core: self-checking bench for the sine phase oscillator.
// Needs only sine_phase_oscillator_core and its package; checks each sample beat against
// a bit-exact fixed-point sine predictor that tracks phase and rate_factor in step.

module tb_sine_phase_oscillator_core;

    localparam int          DIRECTED_ROWS   = 24;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          BEATS_PER_PHASE = 130;
    localparam int          LONG_HOLD       = 400;
    // a wide margin over ~1100 beats
    localparam int          CYCLE_LIMIT     = 400_000;
    localparam logic [31:0] RATE_AT_RESET   = 32'd24932236;
    localparam logic [31:0] RATE_QUARTER    = 32'h4000_0000;
    localparam logic [63:0] TWO_PI_Q29      = 64'd3373259426;
    localparam logic [63:0] FULL_SCALE      = 64'd2147483647;
    localparam logic [63:0] Q30_ONE         = 64'h4000_0000;
    // 256 Hz: the phase step then equals rate_factor exactly
    localparam logic [23:0] FREQ_UNIT_STEP  = 24'h01_0000;

    typedef enum logic [1:0] {
        ROW_BEAT,   // one frequency beat
        ROW_RATE,   // rate_factor write once idle
        ROW_HOME    // bring the phase back to zero via a computed rate
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;
        logic        pinned;
        logic [31:0] sample;
    } t_dir_row;

    // Directed stimulus; pinned samples sit at phase zero or a half turn
    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BEAT, 32'h0000_0000, 1'b1, 32'd0},
        '{ROW_BEAT, 32'h00FF_FFFF, 1'b1, 32'd0},
        '{ROW_BEAT, 32'h0000_0100, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h00AA_AAAA, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0055_5555, 1'b0, 32'd0},
        '{ROW_HOME, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_RATE, RATE_QUARTER,  1'b0, 32'd0},
        '{ROW_BEAT, 32'h0001_0000, 1'b1, 32'd0},
        '{ROW_BEAT, 32'h0001_0000, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0001_0000, 1'b1, 32'd0},
        '{ROW_BEAT, 32'h0001_0000, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0001_0000, 1'b1, 32'd0},
        '{ROW_BEAT, 32'h0000_FFFF, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0001_0001, 1'b0, 32'd0},
        '{ROW_RATE, 32'h0000_0000, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h00FF_FFFF, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0000_0001, 1'b0, 32'd0},
        '{ROW_RATE, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h00FF_FFFF, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0080_0000, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h007F_FFFF, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0000_0001, 1'b0, 32'd0},
        '{ROW_RATE, RATE_AT_RESET, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h0000_BB80, 1'b0, 32'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [23:0] i_frequency   = 24'd0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [31:0] o_sample;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'd0;

    // Bench-side state
    logic        calm            = 1'b0;
    logic        long_hold_due   = 1'b0;
    logic        beat_pinned     = 1'b0;
    logic [31:0] beat_pin_sample = 32'd0;
    logic [31:0] rate_model      = RATE_AT_RESET;
    logic [31:0] phase_model     = 32'd0;
    logic [31:0] expected_samples [$];
    int          mismatches      = 0;
    int          beats_in        = 0;
    int          samples_checked = 0;
    int          rate_writes     = 0;
    int          long_holds      = 0;
    int          cycle_count     = 0;

    sine_phase_oscillator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frequency   (i_frequency),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample      (o_sample),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    // Series term in Q30: g * (1 - x^2/d), truncating
    function automatic logic [63:0] series_term(input logic [63:0] g, input logic [63:0] x2,
                                                input logic [63:0] d);
        return (g * (Q30_ONE - x2 / d)) >> 30;
    endfunction

    // Sine of a Q32 phase, folded into a quarter turn, scaled to full scale
    function automatic logic [31:0] sine_code(input logic [31:0] ph);
        logic [63:0] a, x, x2, x4, g5, g9, g13, s, mag;
        case (ph[31:30])
            2'd0:    a = {32'd0, ph};
            2'd1:    a = 64'h8000_0000 - {32'd0, ph};
            2'd2:    a = {32'd0, ph} - 64'h8000_0000;
            default: a = 64'h1_0000_0000 - {32'd0, ph};
        endcase
        x   = (a * TWO_PI_Q29) >> 31;
        x2  = (x * x) >> 30;
        x4  = (x2 * x2) >> 30;
        g5  = ((x * x4) >> 30) / 64'd120;
        g9  = ((g5 * x4) >> 30) / 64'd3024;
        g13 = ((g9 * x4) >> 30) / 64'd17160;
        s   = series_term(g13, x2, 64'd210) + series_term(g9, x2, 64'd110)
            + series_term(g5, x2, 64'd42) + series_term(x, x2, 64'd6);
        mag = (s * FULL_SCALE) >> 30;
        if (mag > FULL_SCALE) begin
            mag = FULL_SCALE;
        end
        return ph[31] ? 32'd0 - mag[31:0] : mag[31:0];
    endfunction

    function automatic logic [31:0] phase_step(input logic [23:0] freq, input logic [31:0] rate);
        logic [63:0] product;
        product = {40'd0, freq} * {32'd0, rate};
        return product[47:16];
    endfunction

    function automatic int idle_cycles();
        if (calm || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [23:0] pick_frequency();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
            1, 2:    return 24'($urandom_range(0, 255));
            3:       return FREQ_UNIT_STEP + 24'($urandom_range(0, 63)) - 24'd32;
            4:       return 24'd1 << $urandom_range(0, 23);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    // Offer one frequency beat after a random gap; returns on the accepting edge
    task automatic send_beat(input logic [23:0] freq, input logic pinned,
                             input logic [31:0] pin_value);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_frequency     <= freq;
        beat_pinned     <= pinned;
        beat_pin_sample <= pin_value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Stop offering and wait until every expected sample has been taken
    task automatic wait_drain();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_samples.size() != 0);
    endtask

    task automatic write_rate(input logic [31:0] value);
        wait_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        rate_writes++;
    endtask

    // Predictor update and sample check on every accepted beat
    always @(posedge i_clk) begin : sample_checker
        logic [31:0] want;
        if (!i_rst_n) begin
            rate_model  = RATE_AT_RESET;
            phase_model = 32'd0;
        end else begin
            if (i_cfg_wr_en) begin
                rate_model = i_cfg_wr_data;
            end
            if (i_valid && !o_stall) begin
                expected_samples.push_back(beat_pinned ? beat_pin_sample
                                                       : sine_code(phase_model));
                phase_model = phase_model + phase_step(i_frequency, rate_model);
                beats_in++;
            end
            if (o_valid && !i_stall) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample beat with none pending", o_sample, 32'd0);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample !== want) begin
                        report_mismatch("sample", o_sample, want);
                    end
                    samples_checked++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, expected_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Sample side: random stall before each beat, one long hold on request
    initial begin : sample_taker
        int hold;
        do begin
            @(posedge i_clk);
        end while (!i_rst_n);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                hold          = LONG_HOLD;
                long_holds++;
            end else begin
                hold = idle_cycles();
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_valid);
        end
    end

    // Frequency side: directed table, then random phases under varied rates
    initial begin : stimulus
        int          row;
        int          phase;
        int          n;
        logic [31:0] rate;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            case (directed_rows[row].kind)
                ROW_RATE: write_rate(directed_rows[row].value);
                ROW_HOME: begin
                    // with a 256 Hz beat the step is the rate, so this lands on zero
                    wait_drain();
                    write_rate(32'd0 - phase_model);
                    send_beat(FREQ_UNIT_STEP, 1'b0, 32'd0);
                end
                default: send_beat(directed_rows[row].value[23:0], directed_rows[row].pinned,
                                   directed_rows[row].sample);
            endcase
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       rate = RATE_QUARTER;
                1:       rate = 32'hFFFF_FFFF;
                2:       rate = RATE_AT_RESET;
                3:       rate = 32'd0;
                4:       rate = $urandom_range(20_000_000, 30_000_000);
                default: rate = $urandom;
            endcase
            write_rate(rate);
            calm = (phase == 5) || ($urandom_range(0, 4) == 0);
            // hold the sample side off so the core fills and back-pressures
            if (phase == 2) begin
                calm          = 1'b0;
                long_hold_due = 1'b1;
            end
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                send_beat(pick_frequency(), 1'b0, 32'd0);
            end
        end

        wait_drain();
        repeat (40) @(posedge i_clk);

        $display("ran %0d frequency beats over %0d rate settings and %0d long hold(s)",
                 beats_in, rate_writes, long_holds);
        $display("compared %0d samples, %0d mismatch(es)", samples_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
